// ----- rtl/lbng_pkg.sv -----
package lbng_pkg;

    localparam int ROW_STRIDE       = 8;
    localparam int TILE_SIDE_DEFAULT = 8;
    localparam int CELL_BITS        = ROW_STRIDE * ROW_STRIDE;
    localparam int ROW_COUNT_BITS   = 4;
    localparam int LIVE_COUNT_BITS  = 7;

    typedef struct packed {
        logic [CELL_BITS-1:0]  center_cells;
        logic [ROW_STRIDE-1:0] above_row;
        logic [ROW_STRIDE-1:0] below_row;
        logic [ROW_STRIDE-1:0] left_column;
        logic [ROW_STRIDE-1:0] right_column;
        logic                  corner_upper_left;
        logic                  corner_upper_right;
        logic                  corner_lower_left;
        logic                  corner_lower_right;
    } tile_in_t;

    typedef struct packed {
        logic [CELL_BITS-1:0]       next_cells;
        logic [LIVE_COUNT_BITS-1:0] live_count;
        logic                       any_changed;
        logic                       top_changed;
        logic                       bottom_changed;
        logic                       west_changed;
        logic                       east_changed;
        logic                       top_active;
        logic                       bottom_active;
        logic                       west_active;
        logic                       east_active;
    } tile_out_t;

    typedef struct packed {
        logic [ROW_STRIDE-1:0]     next_row;
        logic [ROW_STRIDE-1:0]     changed_row;
        logic [ROW_COUNT_BITS-1:0] live_in_row;
    } lane_res_t;

endpackage

// ----- rtl/life_block_next_generation_top.sv -----
// Life tile stepper, rule B3/S23.
// Input: one transaction per cycle. A tile (rows of ROW_STRIDE bits, cell at
// row r, column c is bit r*8+c) with its halo rows, columns and corners is
// taken on tile at each rising edge where start is high and busy is low.
// busy never rises, so a transaction may be issued every cycle.
// Output: result carries the next tile, its live count and the changed and
// active flags of each edge. done is high for exactly one cycle per
// transaction and the result is valid only in that cycle.
// Pipeline: one row lane per tile row computes the next row, then a merging
// stage assembles the tile, sums the row counts and forms the flags.
// Throughput: one tile per cycle; both register stages take a new tile at every edge.
// Reset clears the valid pipeline; any transaction in flight is dropped.
// The receiver cannot stall: each result is presented once and not held.
// Tile rows and columns at TILE_SIDE and beyond are ignored on input and
// read as zero on output.
module life_block_next_generation_top
    import lbng_pkg::*;
#(
    parameter int TILE_SIDE = TILE_SIDE_DEFAULT
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    input  tile_in_t  tile,
    output tile_out_t result,
    output logic      done
);

    logic [TILE_SIDE+1:0] ext_rows [TILE_SIDE+2];
    lane_res_t            lanes [TILE_SIDE];
    logic                 lanes_valid_reg;
    logic                 accept;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_comb
    begin
        ext_rows[0] = {tile.corner_upper_right, tile.above_row[TILE_SIDE-1:0],
                       tile.corner_upper_left};
        ext_rows[TILE_SIDE+1] = {tile.corner_lower_right, tile.below_row[TILE_SIDE-1:0],
                                 tile.corner_lower_left};
        for (int r = 0; r < TILE_SIDE; r++)
        begin
            ext_rows[r+1] = {tile.right_column[r],
                             tile.center_cells[r*ROW_STRIDE +: TILE_SIDE],
                             tile.left_column[r]};
        end
    end

    for (genvar g = 0; g < TILE_SIDE; g++)
    begin : g_lane
        lbng_lane #(
            .TILE_SIDE (TILE_SIDE)
        ) u_lane (
            .clk       (clk),
            .row_above (ext_rows[g]),
            .row_mid   (ext_rows[g+1]),
            .row_below (ext_rows[g+2]),
            .res       (lanes[g])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lanes_valid_reg <= 1'b0;
        end
        else
        begin
            lanes_valid_reg <= accept;
        end
    end

    lbng_merge #(
        .TILE_SIDE (TILE_SIDE)
    ) u_merge (
        .clk         (clk),
        .rst_n       (rst_n),
        .lanes_valid (lanes_valid_reg),
        .lanes       (lanes),
        .result      (result),
        .done        (done)
    );

`ifndef SYNTHESIS
    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> ##1 done)
        else $error("transaction did not complete two cycles later");
    a_done_cause: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(lanes_valid_reg))
        else $error("done without a transaction in the lanes");
    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !busy)
        else $error("busy raised");
`endif

endmodule

// ----- rtl/lbng_lane.sv -----
module lbng_lane
    import lbng_pkg::*;
#(
    parameter int TILE_SIDE = TILE_SIDE_DEFAULT
)
(
    input  logic                 clk,
    input  logic [TILE_SIDE+1:0] row_above,
    input  logic [TILE_SIDE+1:0] row_mid,
    input  logic [TILE_SIDE+1:0] row_below,
    output lane_res_t            res
);

    lane_res_t res_reg;
    lane_res_t res_next;

    always_comb
    begin
        logic [ROW_COUNT_BITS-1:0] nbr;
        logic                      cur;
        logic                      nv;
        res_next = '0;
        for (int c = 0; c < TILE_SIDE; c++)
        begin
            nbr = ROW_COUNT_BITS'(row_above[c]) + ROW_COUNT_BITS'(row_above[c+1])
                + ROW_COUNT_BITS'(row_above[c+2]) + ROW_COUNT_BITS'(row_mid[c])
                + ROW_COUNT_BITS'(row_mid[c+2]) + ROW_COUNT_BITS'(row_below[c])
                + ROW_COUNT_BITS'(row_below[c+1]) + ROW_COUNT_BITS'(row_below[c+2]);
            cur = row_mid[c+1];
            nv  = (nbr == ROW_COUNT_BITS'(3)) || (cur && (nbr == ROW_COUNT_BITS'(2)));
            res_next.next_row[c]    = nv;
            res_next.changed_row[c] = nv ^ cur;
            res_next.live_in_row    = res_next.live_in_row + ROW_COUNT_BITS'(nv);
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign res = res_reg;

endmodule

// ----- rtl/lbng_merge.sv -----
module lbng_merge
    import lbng_pkg::*;
#(
    parameter int TILE_SIDE = TILE_SIDE_DEFAULT
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      lanes_valid,
    input  lane_res_t lanes [TILE_SIDE],
    output tile_out_t result,
    output logic      done
);

    tile_out_t result_reg;
    tile_out_t result_next;
    logic      done_reg;

    always_comb
    begin
        logic [ROW_STRIDE-1:0] west_bits;
        logic [ROW_STRIDE-1:0] east_bits;
        logic [ROW_STRIDE-1:0] west_live;
        logic [ROW_STRIDE-1:0] east_live;
        result_next = '0;
        west_bits   = '0;
        east_bits   = '0;
        west_live   = '0;
        east_live   = '0;
        for (int r = 0; r < TILE_SIDE; r++)
        begin
            result_next.next_cells[r*ROW_STRIDE +: ROW_STRIDE] = lanes[r].next_row;
            result_next.live_count = result_next.live_count
                                   + LIVE_COUNT_BITS'(lanes[r].live_in_row);
            west_bits[r] = lanes[r].changed_row[0];
            east_bits[r] = lanes[r].changed_row[TILE_SIDE-1];
            west_live[r] = lanes[r].next_row[0];
            east_live[r] = lanes[r].next_row[TILE_SIDE-1];
            if (|lanes[r].changed_row)
            begin
                result_next.any_changed = 1'b1;
            end
        end
        result_next.top_changed    = |lanes[0].changed_row;
        result_next.bottom_changed = |lanes[TILE_SIDE-1].changed_row;
        result_next.west_changed   = |west_bits;
        result_next.east_changed   = |east_bits;
        result_next.top_active     = |lanes[0].next_row;
        result_next.bottom_active  = |lanes[TILE_SIDE-1].next_row;
        result_next.west_active    = |west_live;
        result_next.east_active    = |east_live;
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= lanes_valid;
        end
    end

    assign result = result_reg;
    assign done   = done_reg;

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (result_reg.live_count <= LIVE_COUNT_BITS'(TILE_SIDE * TILE_SIDE)))
        else $error("live count beyond tile area");
    a_edge_implies_any: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && (result_reg.top_changed || result_reg.bottom_changed
                     || result_reg.west_changed || result_reg.east_changed)
        |-> result_reg.any_changed)
        else $error("edge change without any change");
    a_top_active: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (result_reg.top_active == (|result_reg.next_cells[ROW_STRIDE-1:0])))
        else $error("top active flag disagrees with row 0");
    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && (result_reg.next_cells == '0) |-> (result_reg.live_count == '0))
        else $error("empty tile with nonzero count");
`endif

endmodule

// ----- tb/life_tile_checker.sv -----
`timescale 1ns / 100ps

module life_tile_checker
    import lbng_pkg::*;
#(
    parameter int TILE_SIDE = TILE_SIDE_DEFAULT
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  logic      busy,
    input  tile_in_t  tile,
    input  tile_out_t result,
    input  logic      done,
    output int        failures,
    output int        outstanding
);

    tile_out_t expected_tiles[$];
    int        reported;

    function automatic bit cell_at(tile_in_t t, int row, int col);
        if (row < 0)
        begin
            if (col < 0)
                return t.corner_upper_left;
            if (col >= TILE_SIDE)
                return t.corner_upper_right;
            return t.above_row[col];
        end
        if (row >= TILE_SIDE)
        begin
            if (col < 0)
                return t.corner_lower_left;
            if (col >= TILE_SIDE)
                return t.corner_lower_right;
            return t.below_row[col];
        end
        if (col < 0)
            return t.left_column[row];
        if (col >= TILE_SIDE)
            return t.right_column[row];
        return t.center_cells[row * ROW_STRIDE + col];
    endfunction

    function automatic tile_out_t next_generation(tile_in_t t);
        tile_out_t g;
        int        neighbours;
        bit        alive;
        bit        born;
        g = '0;
        for (int row = 0; row < TILE_SIDE; row++)
        begin
            for (int col = 0; col < TILE_SIDE; col++)
            begin
                neighbours = 0;
                for (int dr = -1; dr <= 1; dr++)
                    for (int dc = -1; dc <= 1; dc++)
                        if (dr != 0 || dc != 0)
                            neighbours += cell_at(t, row + dr, col + dc);
                alive = cell_at(t, row, col);
                born  = (neighbours == 3) || (alive && neighbours == 2);
                if (born)
                begin
                    g.next_cells[row * ROW_STRIDE + col] = 1'b1;
                    g.live_count = g.live_count + LIVE_COUNT_BITS'(1);
                    if (row == 0)             g.top_active    = 1'b1;
                    if (row == TILE_SIDE - 1) g.bottom_active = 1'b1;
                    if (col == 0)             g.west_active   = 1'b1;
                    if (col == TILE_SIDE - 1) g.east_active   = 1'b1;
                end
                if (born != alive)
                begin
                    g.any_changed = 1'b1;
                    if (row == 0)             g.top_changed    = 1'b1;
                    if (row == TILE_SIDE - 1) g.bottom_changed = 1'b1;
                    if (col == 0)             g.west_changed   = 1'b1;
                    if (col == TILE_SIDE - 1) g.east_changed   = 1'b1;
                end
            end
        end
        return g;
    endfunction

    task automatic compare_field(input string field, input logic [63:0] want,
                                 input logic [63:0] got);
        if (got !== want)
        begin
            failures++;
            if (reported < 10)
            begin
                reported++;
                $display("%0t: %s mismatch: expected %h, got %h", $realtime, field, want, got);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        tile_out_t want;
        if (!rst_n)
        begin
            expected_tiles.delete();
            outstanding <= 0;
        end
        else
        begin
            if (done)
            begin
                if (expected_tiles.size() == 0)
                begin
                    failures++;
                    if (reported < 10)
                    begin
                        reported++;
                        $display("%0t: result with no transaction outstanding: %h",
                                 $realtime, result);
                    end
                end
                else
                begin
                    want = expected_tiles.pop_front();
                    compare_field("next_cells",     want.next_cells,     result.next_cells);
                    compare_field("live_count",     64'(want.live_count),
                                  64'(result.live_count));
                    compare_field("any_changed",    64'(want.any_changed),
                                  64'(result.any_changed));
                    compare_field("top_changed",    64'(want.top_changed),
                                  64'(result.top_changed));
                    compare_field("bottom_changed", 64'(want.bottom_changed),
                                  64'(result.bottom_changed));
                    compare_field("west_changed",   64'(want.west_changed),
                                  64'(result.west_changed));
                    compare_field("east_changed",   64'(want.east_changed),
                                  64'(result.east_changed));
                    compare_field("top_active",     64'(want.top_active),
                                  64'(result.top_active));
                    compare_field("bottom_active",  64'(want.bottom_active),
                                  64'(result.bottom_active));
                    compare_field("west_active",    64'(want.west_active),
                                  64'(result.west_active));
                    compare_field("east_active",    64'(want.east_active),
                                  64'(result.east_active));
                end
            end
            if (start && !busy)
                expected_tiles = {expected_tiles, next_generation(tile)};
            outstanding <= expected_tiles.size();
        end
    end

    initial
    begin
        failures = 0;
        reported = 0;
    end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps

module testbench
    import lbng_pkg::*;
();

    localparam int RANDOM_TILES = 800;
    localparam int STALL_LIMIT  = 1000;

    logic      clk;
    logic      rst_n;
    logic      start;
    logic      busy;
    tile_in_t  tile;
    tile_out_t result;
    logic      done;
    int        failures;
    int        outstanding;
    int        quiet_cycles;
    bit        idling_allowed;

    life_block_next_generation_top #(.TILE_SIDE(TILE_SIDE_DEFAULT)) DUT
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .tile   (tile),
        .result (result),
        .done   (done)
    );

    life_tile_checker #(.TILE_SIDE(TILE_SIDE_DEFAULT)) tile_checker
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .tile        (tile),
        .result      (result),
        .done        (done),
        .failures    (failures),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    function automatic tile_in_t make_tile(logic [63:0] centre, logic [7:0] above,
                                           logic [7:0] below, logic [7:0] left,
                                           logic [7:0] right, logic [3:0] corners);
        tile_in_t t;
        t.center_cells       = centre;
        t.above_row          = above;
        t.below_row          = below;
        t.left_column        = left;
        t.right_column       = right;
        t.corner_upper_left  = corners[3];
        t.corner_upper_right = corners[2];
        t.corner_lower_left  = corners[1];
        t.corner_lower_right = corners[0];
        return t;
    endfunction

    function automatic logic [63:0] random_bits(int density);
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] c;
        a = {$urandom, $urandom};
        b = {$urandom, $urandom};
        c = {$urandom, $urandom};
        case (density)
            0:       return a & b & c;
            1:       return a & b;
            2:       return a;
            default: return a | b;
        endcase
    endfunction

    function automatic tile_in_t random_tile();
        int density;
        density = $urandom_range(0, 3);
        return make_tile(random_bits(density), 8'(random_bits(density)),
                         8'(random_bits(density)), 8'(random_bits(density)),
                         8'(random_bits(density)), 4'(random_bits(density)));
    endfunction

    task automatic issue_tile(input tile_in_t t);
        while (idling_allowed && $urandom_range(0, 99) < 7)
        begin
            @(negedge clk);
            start = 1'b0;
            tile  = random_tile();
        end
        @(negedge clk);
        start = 1'b1;
        tile  = t;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        rst_n          = 1'b0;
        start          = 1'b0;
        tile           = '0;
        quiet_cycles   = 0;
        idling_allowed = 1'b1;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        issue_tile(make_tile(64'h0, 8'h00, 8'h00, 8'h00, 8'h00, 4'h0));
        issue_tile(make_tile('1, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 4'hF));
        issue_tile(make_tile('1, 8'h00, 8'h00, 8'h00, 8'h00, 4'h0));
        issue_tile(make_tile(64'h0, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 4'hF));
        issue_tile(make_tile(64'h0000_0000_1C00_0000, 8'h00, 8'h00, 8'h00, 8'h00, 4'h0));
        issue_tile(make_tile(64'h0000_0018_1800_0000, 8'h00, 8'h00, 8'h00, 8'h00, 4'h0));
        issue_tile(make_tile(64'h0000_0000_0007_0402, 8'h00, 8'h00, 8'h00, 8'h00, 4'h0));
        issue_tile(make_tile(64'h0000_0010_0000_0000, 8'h00, 8'h00, 8'h00, 8'h00, 4'h0));
        issue_tile(make_tile(64'h0, 8'h01, 8'h00, 8'h01, 8'h00, 4'h8));
        issue_tile(make_tile(64'h0, 8'h80, 8'h00, 8'h00, 8'h01, 4'h4));
        issue_tile(make_tile(64'h0, 8'h00, 8'h01, 8'h80, 8'h00, 4'h2));
        issue_tile(make_tile(64'h0, 8'h00, 8'h80, 8'h00, 8'h80, 4'h1));
        issue_tile(make_tile(64'hAA55_AA55_AA55_AA55, 8'h55, 8'hAA, 8'h55, 8'hAA, 4'hA));
        issue_tile(make_tile(64'h00FF_00FF_00FF_00FF, 8'h00, 8'hFF, 8'h55, 8'hAA, 4'h5));
        issue_tile(make_tile(64'h5555_5555_5555_5555, 8'h55, 8'h55, 8'h00, 8'hFF, 4'h0));
        issue_tile(make_tile(64'h0000_0000_0000_0018, 8'h18, 8'h00, 8'h00, 8'h00, 4'h0));
        issue_tile(make_tile(64'h1800_0000_0000_0000, 8'h00, 8'h18, 8'h00, 8'h00, 4'h0));
        issue_tile(make_tile(64'h0000_0001_0100_0000, 8'h00, 8'h00, 8'h18, 8'h00, 4'h0));
        issue_tile(make_tile(64'h0000_0080_8000_0000, 8'h00, 8'h00, 8'h00, 8'h18, 4'h0));
        issue_tile(make_tile(64'h8100_0000_0000_0081, 8'h81, 8'h81, 8'h81, 8'h81, 4'hF));

        for (int i = 0; i < RANDOM_TILES; i++)
        begin
            idling_allowed = !(i >= 300 && i < 550);
            issue_tile(random_tile());
        end

        @(negedge clk);
        start = 1'b0;
        while (outstanding != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (failures == 0 && outstanding == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
